// File: design/gwna_pkg.sv
// Shared types, constants and elaboration-time helpers for the heat-kernel neighbour averager.
// Depends on nothing; the top level in this folder imports it.
package gwna_pkg;

    localparam int MAX_RUN_DEF        = 32;
    localparam int EXP_TABLE_BITS_DEF = 8;
    localparam int ROOT_SLOTS         = 13;

    localparam int COORD_W   = 24;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 6;
    localparam int CSUM_W    = 32;
    localparam int WVSUM_W   = 56;
    localparam int WSUM_W    = 24;
    localparam int WEIGHT_W  = 17;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_K    = 1'b1;

    typedef struct packed {
        logic                       first;
        logic                       last;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
        logic signed [COORD_W-1:0]  coord_z;
        logic signed [VALUE_W-1:0]  sample_value;
        logic                       sample_valid;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  out_value;
        logic signed [COORD_W-1:0]  out_x;
        logic signed [COORD_W-1:0]  out_y;
        logic signed [COORD_W-1:0]  out_z;
        logic                       result_valid;
    } res_t;

    // Integer square root, bit by bit.
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Slot i holds 2^(-1/2^i) in Q0.32, formed by repeated square roots of one half.
    function automatic logic [32*ROOT_SLOTS-1:0] build_roots(input int n);
        logic [63:0]              cur;
        logic [32*ROOT_SLOTS-1:0] res;
        res = '0;
        cur = 64'h8000_0000;
        res[31:0] = cur[31:0];
        for (int i = 1; i <= n; i++)
        begin
            cur = isqrt64(cur << 32);
            res[i*32 +: 32] = cur[31:0];
        end
        return res;
    endfunction

endpackage

// File: design/gwna_div.sv
// Restoring divider, one quotient bit per cycle, rounding half away from zero.
// Depends on gwna_pkg only through the common project conventions.
module gwna_div #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    busy,
    output logic                    done,
    output logic [NUM_W:0]          quo,
    output logic                    neg
);
    localparam int CNT_W = $clog2(NUM_W + 2);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W:0]   quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;

    logic [NUM_W:0]   num_ext;
    logic [NUM_W:0]   mag;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        num_ext = {num[NUM_W-1], num};
        mag     = num[NUM_W-1] ? (~num_ext + 1'b1) : num_ext;
        trial   = {rem_reg, quo_reg[NUM_W]};
        diff    = trial - {1'b0, den_reg};
        ge      = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W + 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= mag + (NUM_W+1)'(den >> 1);
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[NUM_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-1:0], ge};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;
    assign neg  = neg_reg;

endmodule

// File: design/gaussian_weighted_neighbour_average.sv
// Top level of the heat-kernel neighbour averager: sequencer, shared multiplier, accumulators.
// Depends on gwna_pkg and instantiates gwna_div.
//
// Usage: feed one run per mesh vertex, the centre word first (first=1), then its neighbours,
// the final word marked last=1; a result word appears only for a word with last set.
// A centre word needs no step after it is taken. Nor does a neighbour word whose scalar is
// invalid or that arrives when the run is full. A neighbour word cut off for distance runs
// three squares, two partial products of d^2 times k, a log2(e) scaling and the weighted
// accumulate; any other also runs one step per fraction bit of the table exponent and the
// rounding of the weight, each multiply on one 33x33 signed multiplier. A word with last set
// then adds the mean: one restoring divider, one bit per cycle, forms each quotient, once in
// value mode when the centre is valid and the weight sum is nonzero, and once per axis in
// position mode. item_stall is high while a word is in work. A finished result sits in an
// output register, so the next run may start while it waits. Both configuration registers
// are always writable and should only be changed between runs.
module gaussian_weighted_neighbour_average #(
    parameter int MAX_RUN        = gwna_pkg::MAX_RUN_DEF,
    parameter int EXP_TABLE_BITS = gwna_pkg::EXP_TABLE_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  gwna_pkg::item_t item_word,
    output logic            res_valid,
    input  logic            res_stall,
    output gwna_pkg::res_t  res_word,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_index,
    input  logic [31:0]     cfg_data
);
    import gwna_pkg::*;

    localparam int EB    = EXP_TABLE_BITS;
    localparam int BIT_W = $clog2(EB);
    localparam logic [32*ROOT_SLOTS-1:0] ROOTS = build_roots(EB);

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQX  = 4'd1;
    localparam logic [3:0] S_SQY  = 4'd2;
    localparam logic [3:0] S_SQZ  = 4'd3;
    localparam logic [3:0] S_TLO  = 4'd4;
    localparam logic [3:0] S_THI  = 4'd5;
    localparam logic [3:0] S_LOG  = 4'd6;
    localparam logic [3:0] S_EXP  = 4'd7;
    localparam logic [3:0] S_WGT  = 4'd8;
    localparam logic [3:0] S_ACC  = 4'd9;
    localparam logic [3:0] S_RES  = 4'd10;
    localparam logic [3:0] S_DIV  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Configuration.
    logic        mode_reg;
    logic [31:0] k_reg;

    // Run state.
    logic signed [COORD_W-1:0] cx_reg, cy_reg, cz_reg;
    logic                      centre_ok_reg;
    logic signed [WVSUM_W-1:0] wvs_reg;
    logic [WSUM_W-1:0]         ws_reg;
    logic signed [CSUM_W-1:0]  sx_reg, sy_reg, sz_reg;
    logic [COUNT_W-1:0]        count_reg;

    // Per-word working registers.
    logic signed [COORD_W:0]   dx_reg, dy_reg, dz_reg;
    logic signed [VALUE_W-1:0] val_reg;
    logic                      last_reg;
    logic [49:0]               d2_reg;
    logic [81:0]               t_reg;
    logic [4:0]                n_reg;
    logic [EB-1:0]             f_reg;
    logic [31:0]               acc_reg;
    logic                      acc_one_reg;
    logic [BIT_W-1:0]          bit_reg;
    logic [WEIGHT_W-1:0]       w_reg;
    logic [1:0]                axis_reg;
    res_t                      res_reg;
    res_t                      out_reg;
    logic                      out_valid_reg;

    // Shared multiplier.
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;

    logic        accept;
    logic        is_neighbour;
    logic        t_over;
    logic [31:0] root_sel;
    logic [32:0] acc_full;
    logic [32:0] acc_shift;
    logic [32:0] acc_round;
    logic        value_ok;

    // Divider interface.
    logic                      div_start;
    logic signed [WVSUM_W-1:0] div_num;
    logic [WSUM_W-1:0]         div_den;
    logic                      div_busy;
    logic                      div_done;
    logic [WVSUM_W:0]          div_q;
    logic                      div_neg;
    logic signed [COORD_W-1:0] pos_c;
    logic signed [CSUM_W-1:0]  pos_s;
    logic signed [33:0]        pos_num;
    logic [VALUE_W-1:0]        val_clamped;
    logic [COORD_W-1:0]        pos_clamped;
    logic [WVSUM_W:0]          neg_q;

    assign accept       = item_valid && !item_stall;
    assign item_stall   = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign is_neighbour = !item_word.first && (count_reg < COUNT_W'(MAX_RUN - 1));
    assign value_ok     = centre_ok_reg && (ws_reg != '0);
    assign root_sel     = ROOTS[(EB - int'(bit_reg))*32 +: 32];

    // The kernel is cut off once d^2 * k exceeds 16.0 in Q.40.
    assign t_over = (|t_reg[81:45]) || (t_reg[44] && (|t_reg[43:0]));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SQX:
            begin
                mul_a = 33'(dx_reg);
                mul_b = 33'(dx_reg);
            end
            S_SQY:
            begin
                mul_a = 33'(dy_reg);
                mul_b = 33'(dy_reg);
            end
            S_SQZ:
            begin
                mul_a = 33'(dz_reg);
                mul_b = 33'(dz_reg);
            end
            S_TLO:
            begin
                mul_a = {1'b0, d2_reg[31:0]};
                mul_b = {1'b0, k_reg};
            end
            S_THI:
            begin
                mul_a = {15'b0, d2_reg[49:32]};
                mul_b = {1'b0, k_reg};
            end
            S_LOG:
            begin
                mul_a = {8'b0, t_reg[44:20]};
                mul_b = {2'b0, LOG2E_Q30};
            end
            S_EXP:
            begin
                mul_a = {1'b0, acc_reg};
                mul_b = {1'b0, root_sel};
            end
            S_ACC:
            begin
                mul_a = {16'b0, w_reg};
                mul_b = {val_reg[VALUE_W-1], val_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Weight rounding: the table value shifted by the integer part, then to Q1.16.
    always_comb
    begin
        acc_full  = acc_one_reg ? 33'h1_0000_0000 : {1'b0, acc_reg};
        acc_shift = acc_full >> n_reg;
        acc_round = acc_shift + 33'd32768;
    end

    // Operands for the mean of the current axis or of the value.
    always_comb
    begin
        unique case (axis_reg)
            2'd0:
            begin
                pos_c = cx_reg;
                pos_s = sx_reg;
            end
            2'd1:
            begin
                pos_c = cy_reg;
                pos_s = sy_reg;
            end
            default:
            begin
                pos_c = cz_reg;
                pos_s = sz_reg;
            end
        endcase
        pos_num = (34'(pos_c) <<< 1) + 34'(pos_c) + 34'(pos_s);
        div_num = mode_reg ? WVSUM_W'(pos_num) : wvs_reg;
        div_den = mode_reg ? (WSUM_W'(count_reg) + WSUM_W'(3)) : ws_reg;
        div_start = (state_reg == S_RES) && (mode_reg || value_ok);
    end

    // Saturation of the rounded quotient to the output ranges.
    always_comb
    begin
        neg_q = ~div_q + 1'b1;
        if (div_neg)
        begin
            val_clamped = (div_q > (WVSUM_W+1)'(64'h8000_0000)) ? 32'h8000_0000
                                                                 : neg_q[VALUE_W-1:0];
            pos_clamped = (div_q > (WVSUM_W+1)'(64'h80_0000)) ? 24'h80_0000
                                                               : neg_q[COORD_W-1:0];
        end
        else
        begin
            val_clamped = (div_q > (WVSUM_W+1)'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                                 : div_q[VALUE_W-1:0];
            pos_clamped = (div_q > (WVSUM_W+1)'(64'h7F_FFFF)) ? 24'h7F_FFFF
                                                               : div_q[COORD_W-1:0];
        end
    end

    gwna_div #(
        .NUM_W (WVSUM_W),
        .DEN_W (WSUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_q),
        .neg   (div_neg)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (is_neighbour && item_word.sample_valid)
                    begin
                        state_next = S_SQX;
                    end
                    else if (item_word.last)
                    begin
                        state_next = S_RES;
                    end
                end
            end
            S_SQX: state_next = S_SQY;
            S_SQY: state_next = S_SQZ;
            S_SQZ: state_next = S_TLO;
            S_TLO: state_next = S_THI;
            S_THI: state_next = S_LOG;
            S_LOG: state_next = t_over ? S_ACC : S_EXP;
            S_EXP:
            begin
                if (bit_reg == BIT_W'(EB - 1))
                begin
                    state_next = S_WGT;
                end
            end
            S_WGT: state_next = S_ACC;
            S_ACC: state_next = last_reg ? S_RES : S_IDLE;
            S_RES: state_next = div_start ? S_DIV : S_OUT;
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = (mode_reg && (axis_reg != 2'd2)) ? S_RES : S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !res_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= 1'b0;
            k_reg         <= 32'd65536;
            out_valid_reg <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            cz_reg        <= '0;
            centre_ok_reg <= 1'b0;
            wvs_reg       <= '0;
            ws_reg        <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            sz_reg        <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_MODE: mode_reg <= cfg_data[0];
                    CFG_K:    k_reg    <= cfg_data;
                    default:  k_reg    <= k_reg;
                endcase
            end

            if ((state_reg == S_OUT) && (!out_valid_reg || !res_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !res_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (accept)
            begin
                if (item_word.first)
                begin
                    // A centre word restarts every sum; its own weight is exactly 1.0.
                    cx_reg        <= item_word.coord_x;
                    cy_reg        <= item_word.coord_y;
                    cz_reg        <= item_word.coord_z;
                    centre_ok_reg <= item_word.sample_valid;
                    sx_reg        <= '0;
                    sy_reg        <= '0;
                    sz_reg        <= '0;
                    count_reg     <= '0;
                    if (item_word.sample_valid)
                    begin
                        wvs_reg <= {{(WVSUM_W-VALUE_W-16){item_word.sample_value[VALUE_W-1]}},
                                    item_word.sample_value, 16'b0};
                        ws_reg  <= WSUM_W'(32'd65536);
                    end
                    else
                    begin
                        wvs_reg <= '0;
                        ws_reg  <= '0;
                    end
                end
                else if (is_neighbour)
                begin
                    sx_reg    <= sx_reg + CSUM_W'(item_word.coord_x);
                    sy_reg    <= sy_reg + CSUM_W'(item_word.coord_y);
                    sz_reg    <= sz_reg + CSUM_W'(item_word.coord_z);
                    count_reg <= count_reg + 1'b1;
                end
            end

            if (state_reg == S_ACC)
            begin
                wvs_reg <= wvs_reg + mul_p[WVSUM_W-1:0];
                ws_reg  <= ws_reg + WSUM_W'(w_reg);
            end
        end
    end

    // Working registers of one word; no reset needed.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    dx_reg   <= (COORD_W+1)'(item_word.coord_x) - (COORD_W+1)'(cx_reg);
                    dy_reg   <= (COORD_W+1)'(item_word.coord_y) - (COORD_W+1)'(cy_reg);
                    dz_reg   <= (COORD_W+1)'(item_word.coord_z) - (COORD_W+1)'(cz_reg);
                    val_reg  <= item_word.sample_value;
                    last_reg <= item_word.last;
                    axis_reg <= 2'd0;
                end
            end
            S_SQX: d2_reg <= mul_p[49:0];
            S_SQY: d2_reg <= d2_reg + mul_p[49:0];
            S_SQZ: d2_reg <= d2_reg + mul_p[49:0];
            S_TLO: t_reg  <= {18'b0, mul_p[63:0]};
            S_THI: t_reg  <= t_reg + {mul_p[49:0], 32'b0};
            S_LOG:
            begin
                w_reg       <= '0;
                n_reg       <= mul_p[54:50];
                f_reg       <= mul_p[49 -: EB];
                acc_one_reg <= 1'b1;
                bit_reg     <= '0;
            end
            S_EXP:
            begin
                if (f_reg[bit_reg])
                begin
                    acc_one_reg <= 1'b0;
                    acc_reg     <= acc_one_reg ? root_sel : mul_p[63:32];
                end
                bit_reg <= bit_reg + 1'b1;
            end
            S_WGT:
            begin
                w_reg <= (n_reg >= 5'd17) ? '0 : acc_round[32:16];
            end
            S_RES:
            begin
                if (!mode_reg)
                begin
                    res_reg.out_x        <= '0;
                    res_reg.out_y        <= '0;
                    res_reg.out_z        <= '0;
                    res_reg.out_value    <= '0;
                    res_reg.result_valid <= value_ok;
                end
                else
                begin
                    res_reg.out_value    <= '0;
                    res_reg.result_valid <= 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (!mode_reg)
                    begin
                        res_reg.out_value <= val_clamped;
                    end
                    else
                    begin
                        unique case (axis_reg)
                            2'd0:    res_reg.out_x <= pos_clamped;
                            2'd1:    res_reg.out_y <= pos_clamped;
                            default: res_reg.out_z <= pos_clamped;
                        endcase
                        axis_reg <= axis_reg + 1'b1;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !res_stall)
                begin
                    out_reg <= res_reg;
                end
            end
            default:
            begin
                d2_reg <= d2_reg;
            end
        endcase
    end

    assign res_valid = out_valid_reg;
    assign res_word  = out_reg;

    // A new result word only appears after the sequencer has passed through its output state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == S_OUT))
        else $error("result word raised outside the output state");

    // The divider is never restarted while a quotient is still being formed.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // The neighbour count stays within the run limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_RUN - 1))
        else $error("neighbour count beyond run limit");

    // A word is only taken while no earlier word is still in work.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> item_stall)
        else $error("input open while busy");

endmodule

// File: bench/tb_gaussian_weighted_neighbour_average.sv
// Self-checking testbench for the heat-kernel neighbour averager.
// Depends on gwna_pkg and the top level gaussian_weighted_neighbour_average; nothing else.
module tb_gaussian_weighted_neighbour_average;

    import gwna_pkg::*;

    localparam int TAB_BITS   = EXP_TABLE_BITS_DEF;
    localparam int TAB_SIZE   = 1 << TAB_BITS;
    localparam int RUN_CAP    = MAX_RUN_DEF;
    localparam int CYCLE_CAP  = 800000;
    localparam int DRAIN_WAIT = 60;

    // The scoreboard keeps its own copy of the block's registers and run state.
    // Every accepted input word is folded into that state, and a word with last set
    // queues the mean that the block must produce.
    class smoothing_board;
        longint unsigned exp_tab[TAB_SIZE];
        bit              pos_mode;
        longint unsigned kval;
        longint          cx, cy, cz;
        bit              centre_ok;
        longint          wvsum;
        longint unsigned wsum;
        longint          csum[3];
        int              count;
        res_t            means[$];
        int              errors;

        function new();
            longint unsigned roots[TAB_BITS+1];
            longint unsigned acc;
            roots[0] = 64'h8000_0000;
            for (int i = 1; i <= TAB_BITS; i++)
            begin
                roots[i] = root_of(roots[i-1] << 32);
            end
            for (int j = 0; j < TAB_SIZE; j++)
            begin
                acc = 64'h1_0000_0000;
                for (int b = 0; b < TAB_BITS; b++)
                begin
                    if ((j >> b) & 1)
                    begin
                        acc = (acc * roots[TAB_BITS-b]) >> 32;
                    end
                end
                exp_tab[j] = acc;
            end
            pos_mode = 0;
            kval = 65536;
            errors = 0;
        endfunction

        function longint unsigned root_of(longint unsigned v_in);
            longint unsigned v, r, b;
            v = v_in;
            r = 0;
            b = 64'h1 << 62;
            while (b > v)
            begin
                b = b >> 2;
            end
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function void set_reg(logic idx, logic [31:0] data);
            if (idx == CFG_MODE)
            begin
                pos_mode = data[0];
            end
            else
            begin
                kval = data;
            end
        endfunction

        function longint unsigned heat_weight(longint unsigned d2);
            longint unsigned t, u, n, f;
            if (kval != 0 && d2 > (64'h1 << 44) / kval)
            begin
                return 0;
            end
            t = d2 * kval;
            u = ((t >> 20) * 64'(LOG2E_Q30)) >> (50 - TAB_BITS);
            n = u >> TAB_BITS;
            f = u & (TAB_SIZE - 1);
            if (n >= 17)
            begin
                return 0;
            end
            return ((exp_tab[f] >> n) + 32768) >> 16;
        endfunction

        // Rounds to nearest with ties away from zero, then clamps.
        function longint round_div(longint num, longint den, longint lo, longint hi);
            longint unsigned a, q;
            longint r;
            a = (num < 0) ? -num : num;
            q = (a + den / 2) / den;
            r = (num < 0) ? -longint'(q) : longint'(q);
            return (r < lo) ? lo : ((r > hi) ? hi : r);
        endfunction

        function void absorb_word(item_t w);
            longint x, y, z, v, dx, dy, dz, den;
            longint unsigned wt;
            longint c[3];
            res_t r;
            x = w.coord_x;
            y = w.coord_y;
            z = w.coord_z;
            v = w.sample_value;
            if (w.first)
            begin
                cx = x;
                cy = y;
                cz = z;
                centre_ok = w.sample_valid;
                csum = '{0, 0, 0};
                count = 0;
                wvsum = 0;
                wsum = 0;
                if (w.sample_valid)
                begin
                    wt = heat_weight(0);
                    wvsum = longint'(wt) * v;
                    wsum = wt;
                end
            end
            else if (count < RUN_CAP - 1)
            begin
                dx = x - cx;
                dy = y - cy;
                dz = z - cz;
                csum[0] += x;
                csum[1] += y;
                csum[2] += z;
                count++;
                if (w.sample_valid)
                begin
                    wt = heat_weight(dx*dx + dy*dy + dz*dz);
                    wvsum += longint'(wt) * v;
                    wsum += wt;
                end
            end
            if (!w.last)
            begin
                return;
            end
            r = '0;
            if (!pos_mode)
            begin
                r.result_valid = centre_ok && wsum != 0;
                if (r.result_valid)
                begin
                    r.out_value = VALUE_W'(round_div(wvsum, wsum, -64'sd2147483648,
                                                     64'sd2147483647));
                end
            end
            else
            begin
                den = 3 + count;
                c[0] = cx;
                c[1] = cy;
                c[2] = cz;
                r.out_x = COORD_W'(round_div(3*c[0] + csum[0], den, -8388608, 8388607));
                r.out_y = COORD_W'(round_div(3*c[1] + csum[1], den, -8388608, 8388607));
                r.out_z = COORD_W'(round_div(3*c[2] + csum[2], den, -8388608, 8388607));
                r.result_valid = 1;
            end
            means.push_back(r);
        endfunction

        function void compare_word(res_t got);
            res_t want;
            if (means.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("unexpected result word %h", got);
                end
                return;
            end
            want = means.pop_front();
            if (got.out_value !== want.out_value || got.out_x !== want.out_x
                || got.out_y !== want.out_y || got.out_z !== want.out_z
                || got.result_valid !== want.result_valid)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch: value %h/%h x %h/%h y %h/%h z %h/%h ok %b/%b (exp/act)",
                             want.out_value, got.out_value, want.out_x, got.out_x,
                             want.out_y, got.out_y, want.out_z, got.out_z,
                             want.result_valid, got.result_valid);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    item_t       item_word;
    logic        res_valid;
    logic        res_stall;
    res_t        res_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    smoothing_board board;
    int          cycles;
    bit          tx_idle;
    bit          rx_idle;
    bit          long_hold;

    gaussian_weighted_neighbour_average u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_word  (item_word),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_word   (res_word),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // A hard ceiling on the run length; a hung handshake ends here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Results are sampled at the rising edge, before the block updates its outputs.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            board.compare_word(res_word);
        end
    end

    // The result side draws a stall length per word. When the test asks for a long
    // hold, the receiver stalls once so that the output register fills and the block
    // pushes back on its input.
    initial
    begin
        int n;
        bit held;
        held = 0;
        res_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = rx_idle ? $urandom_range(0, 10) : 0;
            if (long_hold && !held)
            begin
                n = 500;
                held = 1;
            end
            if (n > 0)
            begin
                @(negedge clk);
                res_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            res_stall <= 1'b0;
            do @(posedge clk); while (!res_valid);
        end
    end

    // Offers one input word, after a random gap when tx_idle is set, and holds it until accepted.
    task automatic send_word(input item_t w);
        int gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item_word <= w;
        do @(posedge clk); while (item_stall);
        board.absorb_word(w);
    endtask

    // Lowers valid, then waits until every queued mean has come back and any trailing
    // neighbour word has had time to finish, so that a register write sees an idle block.
    task automatic drain_block();
        @(negedge clk);
        item_valid <= 1'b0;
        while (board.means.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic item_t make_word(bit first, bit last, int x, int y, int z,
                                        logic [31:0] v, bit ok);
        item_t w;
        w.first = first;
        w.last = last;
        w.coord_x = x[23:0];
        w.coord_y = y[23:0];
        w.coord_z = z[23:0];
        w.sample_value = v;
        w.sample_valid = ok;
        return w;
    endfunction

    // One run: a centre anywhere in range, then neighbours scattered around it. A small
    // spread keeps the weights alive; a large one drives them to zero.
    task automatic send_run(input int nb, input int spread);
        int    x, y, z;
        item_t w;
        x = $urandom;
        y = $urandom;
        z = $urandom;
        x = x >>> 8;
        y = y >>> 8;
        z = z >>> 8;
        send_word(make_word(1, nb == 0, x, y, z, $urandom, $urandom_range(0, 9) != 0));
        for (int i = 1; i <= nb; i++)
        begin
            w = make_word(0, i == nb,
                          x + $urandom_range(0, 2*spread) - spread,
                          y + $urandom_range(0, 2*spread) - spread,
                          z + $urandom_range(0, 2*spread) - spread,
                          $urandom, $urandom_range(0, 7) != 0);
            send_word(w);
        end
    endtask

    task automatic random_phase(input int items);
        int sent;
        int nb;
        int spread;
        item_t w;
        sent = 0;
        while (sent < items)
        begin
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 9))
                0: nb = $urandom_range(33, 40);
                1: nb = 0;
                default: nb = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 3))
                0: spread = 8388607;
                1: spread = 256;
                default: spread = 8192;
            endcase
            if ($urandom_range(0, 9) == 0)
            begin
                // Noise: a word with every field random, including stray first and last.
                w.first = 1'($urandom);
                w.last = 1'($urandom);
                w.coord_x = COORD_W'($urandom);
                w.coord_y = COORD_W'($urandom);
                w.coord_z = COORD_W'($urandom);
                w.sample_value = $urandom;
                w.sample_valid = 1'($urandom);
                send_word(w);
                sent++;
            end
            else
            begin
                send_run(nb, spread);
                sent += nb + 1;
            end
        end
    endtask

    initial
    begin
        logic [31:0] kset[8];
        board = new();
        tx_idle = 0;
        rx_idle = 0;
        long_hold = 0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item_word = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MODE;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset settings: a lone centre, an invalid centre,
        // extreme values and coordinates, and a neighbour arriving after a last.
        send_word(make_word(1, 1, 0, 0, 0, 32'h7FFF_FFFF, 1));
        send_word(make_word(1, 0, 8388607, -8388608, 8388607, 32'h8000_0000, 1));
        send_word(make_word(0, 1, 8388607, -8388608, 8388606, 32'h7FFF_FFFF, 1));
        send_word(make_word(0, 1, 8388600, -8388600, 8388607, 32'h8000_0000, 1));
        send_word(make_word(1, 0, 100, 200, 300, 32'h0001_0000, 0));
        send_word(make_word(0, 1, 101, 201, 301, 32'h0002_0000, 1));
        send_word(make_word(1, 0, -5, -5, -5, 32'hFFFF_0000, 1));
        send_word(make_word(0, 0, -8388608, 8388607, 0, 32'h1234_5678, 1));
        send_word(make_word(0, 1, 0, 0, 0, 32'h0, 0));
        drain_block();

        // Position mode at the coordinate extremes, then zero k in value mode.
        write_reg(CFG_MODE, 32'd1);
        send_word(make_word(1, 0, 8388607, 8388607, -8388608, 32'h0, 0));
        send_word(make_word(0, 1, 8388607, 8388607, -8388608, 32'h0, 0));
        send_word(make_word(1, 1, -8388608, 0, 8388607, 32'hFFFF_FFFF, 1));
        send_word(make_word(1, 0, -8388608, -8388608, -8388608, 32'h0, 1));
        send_word(make_word(0, 1, 8388607, 8388607, 8388607, 32'h0, 1));
        drain_block();
        write_reg(CFG_MODE, 32'd0);
        write_reg(CFG_K, 32'd0);
        send_word(make_word(1, 0, 0, 0, 0, 32'h0003_0000, 1));
        send_word(make_word(0, 0, 8388607, 8388607, 8388607, 32'h0001_0000, 1));
        send_word(make_word(0, 1, -8388608, 0, 0, 32'hFFFF_0000, 1));
        drain_block();

        // Random phases sweep both modes and the extremes of k. The third phase opens
        // with a long receiver hold while the sender keeps offering words.
        kset = '{32'hFFFF_FFFF, 32'd65536, 32'd0, 32'd1, 32'd4096, 32'h0010_0000,
                 32'h8000_0000, 32'd300};
        for (int p = 0; p < 8; p++)
        begin
            write_reg(CFG_MODE, p % 2);
            write_reg(CFG_K, (p == 7) ? $urandom : kset[p]);
            if (p == 2)
            begin
                long_hold = 1;
            end
            random_phase(92);
            drain_block();
        end

        board.errors += board.means.size();
        if (board.errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
